// ===== hdl/mlfq_pkg.sv =====
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam int SLOT_W       = 5;
    localparam int QW           = 16;
    localparam int CFG_W        = 16;
    localparam int NUM_SLOTS_D  = 32;
    localparam int NUM_LEVELS_D = 5;

    localparam logic [QW-1:0] QBASE_RST  = 16'd16;
    localparam logic [QW-1:0] BOOST_RST  = 16'd100;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_BLOCK  = 2'd3
    } t_op;

    typedef enum logic {
        CFG_QBASE = 1'b0,
        CFG_BOOST = 1'b1
    } t_cfg_idx;

endpackage

// ===== hdl/mlfq_ram.sv =====
`timescale 1ns / 1ps
module mlfq_ram #(
    parameter int DEPTH = mlfq_pkg::NUM_SLOTS_D,
    parameter int WIDTH = mlfq_pkg::SLOT_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mlfq_scheduler.sv =====
// channel   direction  handshake                    word
// command   in         start high, busy low         i_opcode, i_slot, i_is_system
// result    out        o_result_valid, one cycle    o_running_slot, o_quantum_left,
//                                                   o_switched, o_status
// config    in         i_cfg_valid and o_cfg_ready  i_cfg_index, i_cfg_data
//
// add, block: done in the execute state; remove: execute, then an unlink state.
// tick: execute, tick, then select and pop unless the running slot keeps its turn;
// a boost first moves each higher level into level 0 via the next-link memory walk.
// synchronous active-low reset clears queues, counters, state; not command/walk regs.
// the result strobe cannot be stalled; busy stays high until the result cycle ends.
`timescale 1ns / 1ps
module mlfq_scheduler #(
    parameter int NUM_SLOTS  = mlfq_pkg::NUM_SLOTS_D,
    parameter int NUM_LEVELS = mlfq_pkg::NUM_LEVELS_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [mlfq_pkg::SLOT_W-1:0] i_slot,
    input  logic                        i_is_system,
    output logic                        o_result_valid,
    output logic [mlfq_pkg::SLOT_W-1:0] o_running_slot,
    output logic [mlfq_pkg::QW-1:0]     o_quantum_left,
    output logic                        o_switched,
    output logic                        o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [mlfq_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int PW = mlfq_pkg::SLOT_W;
    localparam int QW = mlfq_pkg::QW;
    localparam logic [PW:0]   SLOT_LIM = (PW+1)'(NUM_SLOTS);
    localparam logic [LW-1:0] LVL_MAX  = LW'(NUM_LEVELS - 1);
    localparam logic [LW:0]   LVL_END  = (LW+1)'(NUM_LEVELS);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_RM, S_BST, S_WALK, S_TICK, S_SEL, S_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    logic [1:0]    r_op;
    logic [PW-1:0] r_s;
    logic          r_sys;
    logic [SW-1:0] r_before;
    logic          r_status, n_status;

    logic [SW-1:0] r_head [NUM_LEVELS];
    logic [SW-1:0] n_head [NUM_LEVELS];
    logic [SW-1:0] r_tail [NUM_LEVELS];
    logic [SW-1:0] n_tail [NUM_LEVELS];
    logic [CW-1:0] r_cnt  [NUM_LEVELS];
    logic [CW-1:0] n_cnt  [NUM_LEVELS];
    logic [NUM_SLOTS-1:0] r_queued, n_queued;
    logic [31:0]   r_tick, n_tick, r_last, n_last;
    logic [SW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_clvl, n_clvl;
    logic [QW-1:0] r_q, n_q;
    logic          r_blk, n_blk;
    logic [QW-1:0] r_qbase, r_bint;

    logic [LW:0]   r_blv, n_blv;
    logic [SW-1:0] r_wa, n_wa, r_pw, n_pw;
    logic [CW-1:0] r_k, n_k;
    logic [LW-1:0] r_hi, n_hi;

    logic          nx_we, pl_we;
    logic [SW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic [SW-1:0] pl_waddr, pl_raddr;
    logic [LW+SW-1:0] pl_wdata, pl_rdata;

    mlfq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW)) u_next (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    mlfq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(LW+SW)) u_prev_lvl (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    logic          s_valid;
    logic [SW-1:0] s_idx;
    logic          hi_any;
    logic [LW-1:0] hi_lvl;
    logic [LW-1:0] rm_lvl;
    logic [SW-1:0] rm_prev;
    logic [QW-1:0] q_dec;
    logic [31:0]   tick_inc;
    logic          push_en;
    logic [LW-1:0] push_lv;
    logic [SW-1:0] push_s;
    logic [LW-1:0] blv_i;

    assign s_idx   = r_s[SW-1:0];
    assign s_valid = (r_s != '0) && ({1'b0, r_s} < SLOT_LIM);
    assign rm_prev = pl_rdata[SW-1:0];
    assign rm_lvl  = (32'(pl_rdata[LW+SW-1:SW]) < NUM_LEVELS) ? pl_rdata[LW+SW-1:SW] : LVL_MAX;
    assign q_dec   = r_q - 1'b1;
    assign tick_inc = r_tick + 32'd1;
    assign blv_i   = r_blv[LW-1:0];

    always_comb begin
        hi_any = 1'b0;
        hi_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_cnt[i] != '0) begin
                hi_any = 1'b1;
                hi_lvl = LW'(i);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = r_status;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_queued = r_queued;
        n_tick   = r_tick;
        n_last   = r_last;
        n_cur    = r_cur;
        n_clvl   = r_clvl;
        n_q      = r_q;
        n_blk    = r_blk;
        n_blv    = r_blv;
        n_wa     = r_wa;
        n_pw     = r_pw;
        n_k      = r_k;
        n_hi     = r_hi;
        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        nx_raddr = s_idx;
        pl_we    = 1'b0;
        pl_waddr = '0;
        pl_wdata = '0;
        pl_raddr = s_idx;
        push_en  = 1'b0;
        push_lv  = '0;
        push_s   = '0;

        case (r_state)
            S_IDLE: begin
                if (start && !r_done) begin
                    n_state  = S_EXEC;
                    n_status = 1'b0;
                end
            end
            S_EXEC: begin
                case (mlfq_pkg::t_op'(r_op))
                    mlfq_pkg::OP_ADD: begin
                        if (!s_valid || r_queued[s_idx] || s_idx == r_cur) begin
                            n_status = 1'b1;
                        end else begin
                            push_en = 1'b1;
                            push_lv = r_sys ? LW'(0) : LW'(1);
                            push_s  = s_idx;
                        end
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                    mlfq_pkg::OP_REMOVE: begin
                        if (!s_valid || !r_queued[s_idx]) begin
                            n_status = 1'b1;
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                        end else begin
                            n_state = S_RM;
                        end
                    end
                    mlfq_pkg::OP_BLOCK: begin
                        if (!s_valid || s_idx != r_cur) begin
                            n_status = 1'b1;
                        end else begin
                            n_q   = '0;
                            n_blk = 1'b1;
                        end
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                    default: begin
                        n_tick = tick_inc;
                        if ((tick_inc - r_last) >= {16'd0, r_bint}) begin
                            n_last  = tick_inc;
                            n_blv   = (LW+1)'(1);
                            n_state = S_BST;
                        end else begin
                            n_state = S_TICK;
                        end
                    end
                endcase
            end
            S_RM: begin
                if (r_head[rm_lvl] == s_idx) begin
                    n_head[rm_lvl] = nx_rdata;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = rm_prev;
                    nx_wdata = nx_rdata;
                end
                if (r_tail[rm_lvl] == s_idx) begin
                    n_tail[rm_lvl] = rm_prev;
                end else begin
                    pl_we    = 1'b1;
                    pl_waddr = nx_rdata;
                    pl_wdata = {rm_lvl, rm_prev};
                end
                if (r_cnt[rm_lvl] != '0) begin
                    n_cnt[rm_lvl] = r_cnt[rm_lvl] - 1'b1;
                end
                n_queued[s_idx] = 1'b0;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_BST: begin
                if (r_blv == LVL_END) begin
                    n_state = S_TICK;
                end else if (r_cnt[blv_i] == '0) begin
                    n_blv = r_blv + 1'b1;
                end else begin
                    if (r_cnt[0] != '0) begin
                        nx_we    = 1'b1;
                        nx_waddr = r_tail[0];
                        nx_wdata = r_head[blv_i];
                    end else begin
                        n_head[0] = r_head[blv_i];
                    end
                    n_tail[0]     = r_tail[blv_i];
                    n_cnt[0]      = r_cnt[0] + r_cnt[blv_i];
                    n_cnt[blv_i]  = '0;
                    n_wa          = r_head[blv_i];
                    n_pw          = r_tail[0];
                    n_k           = r_cnt[blv_i];
                    nx_raddr      = r_head[blv_i];
                    n_state       = S_WALK;
                end
            end
            S_WALK: begin
                pl_we    = 1'b1;
                pl_waddr = r_wa;
                pl_wdata = {LW'(0), r_pw};
                n_pw     = r_wa;
                n_wa     = nx_rdata;
                nx_raddr = nx_rdata;
                n_k      = r_k - 1'b1;
                if (r_k == CW'(1)) begin
                    n_blv   = r_blv + 1'b1;
                    n_state = S_BST;
                end
            end
            S_TICK: begin
                n_blk   = 1'b0;
                n_state = S_SEL;
                if (r_cur != '0 && !r_blk) begin
                    if (r_q != '0) begin
                        n_q = q_dec;
                    end
                    if (r_q != '0 && q_dec != '0 && (!hi_any || hi_lvl >= r_clvl)) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        push_en = 1'b1;
                        push_lv = (r_clvl == LVL_MAX) ? r_clvl : r_clvl + 1'b1;
                        push_s  = r_cur;
                    end
                end
            end
            S_SEL: begin
                if (!hi_any) begin
                    n_cur   = '0;
                    n_q     = '0;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    nx_raddr = r_head[hi_lvl];
                    n_hi     = hi_lvl;
                    n_state  = S_POP;
                end
            end
            S_POP: begin
                n_cnt[r_hi] = r_cnt[r_hi] - 1'b1;
                if (r_cnt[r_hi] != CW'(1)) begin
                    n_head[r_hi] = nx_rdata;
                end
                n_queued[r_head[r_hi]] = 1'b0;
                n_cur   = r_head[r_hi];
                n_clvl  = r_hi;
                n_q     = r_qbase >> r_hi;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_en) begin
            if (r_cnt[push_lv] != '0) begin
                nx_we    = 1'b1;
                nx_waddr = r_tail[push_lv];
                nx_wdata = push_s;
            end else begin
                n_head[push_lv] = push_s;
            end
            pl_we    = 1'b1;
            pl_waddr = push_s;
            pl_wdata = {push_lv, r_tail[push_lv]};
            n_tail[push_lv]  = push_s;
            n_cnt[push_lv]   = r_cnt[push_lv] + 1'b1;
            n_queued[push_s] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_status <= 1'b0;
            r_queued <= '0;
            r_tick   <= '0;
            r_last   <= '0;
            r_cur    <= '0;
            r_clvl   <= '0;
            r_q      <= '0;
            r_blk    <= 1'b0;
            r_blv    <= '0;
            r_k      <= '0;
            r_hi     <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_status <= n_status;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_queued <= n_queued;
            r_tick   <= n_tick;
            r_last   <= n_last;
            r_cur    <= n_cur;
            r_clvl   <= n_clvl;
            r_q      <= n_q;
            r_blk    <= n_blk;
            r_blv    <= n_blv;
            r_k      <= n_k;
            r_hi     <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa <= n_wa;
        r_pw <= n_pw;
        if (start && !busy) begin
            r_op     <= i_opcode;
            r_s      <= i_slot;
            r_sys    <= i_is_system;
            r_before <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbase <= mlfq_pkg::QBASE_RST;
            r_bint  <= mlfq_pkg::BOOST_RST;
        end else if (i_cfg_valid) begin
            case (mlfq_pkg::t_cfg_idx'(i_cfg_index))
                mlfq_pkg::CFG_QBASE: r_qbase <= i_cfg_data;
                mlfq_pkg::CFG_BOOST: r_bint  <= i_cfg_data;
                default: r_bint <= r_bint;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE) || r_done;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_done;
    assign o_running_slot = PW'(r_cur);
    assign o_quantum_left = r_q;
    assign o_switched     = (r_cur != r_before);
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_idle_zero_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_running_slot == '0) |-> o_quantum_left == '0)
        else $error("idle slot with quantum left");

    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_switched) |-> !o_status)
        else $error("switch on ignored item");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_valid))
        else $error("accepted word not held busy");
`endif

endmodule
